FILE: rtl/trmm_pkg.sv
// Package for the thermal ROI statistics block: widths, payload structs,
// register and divider codes, controller/datapath command and status types.
// No dependencies.
package trmm_pkg;

  localparam int TEMP_BITS     = 16;
  localparam int MAX_DIM       = 1024;
  localparam int DIM_BITS      = $clog2(MAX_DIM);
  localparam int MDIM_BITS     = 11;
  localparam int IMG_BITS      = 13;
  localparam int COORD_BITS    = 14;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 14;
  localparam int SUM_BITS      = 37;
  localparam int CNT_BITS      = 21;
  localparam int PROD_BITS     = IMG_BITS + MDIM_BITS;

  localparam logic [IMG_BITS-1:0]  IMG_W_RST = IMG_BITS'(640);
  localparam logic [IMG_BITS-1:0]  IMG_H_RST = IMG_BITS'(512);
  localparam logic [MDIM_BITS-1:0] MAT_W_RST = MDIM_BITS'(640);
  localparam logic [MDIM_BITS-1:0] MAT_H_RST = MDIM_BITS'(512);

  typedef logic signed [TEMP_BITS-1:0] temp_t;

  localparam temp_t TEMP_MAX = {1'b0, {(TEMP_BITS-1){1'b1}}};
  localparam temp_t TEMP_MIN = {1'b1, {(TEMP_BITS-1){1'b0}}};

  typedef struct packed {
    temp_t temp_sample;
    logic  frame_last;
  } sample_t;

  typedef struct packed {
    logic                roi_valid;
    temp_t               roi_min;
    temp_t               roi_max;
    temp_t               roi_avg;
    logic [CNT_BITS-1:0] roi_count;
    temp_t               frame_min;
    temp_t               frame_max;
    temp_t               frame_avg;
  } result_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_MATRIX_WIDTH,
    REG_MATRIX_HEIGHT,
    REG_ROI_LEFT,
    REG_ROI_TOP,
    REG_ROI_RIGHT,
    REG_ROI_BOTTOM
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BND_X_LO,
    BND_Y_LO,
    BND_X_HI,
    BND_Y_HI
  } bnd_e;

  typedef enum logic [1:0] {
    DIV_BOUND,
    DIV_ROI,
    DIV_FRAME
  } div_sel_e;

  typedef struct packed {
    logic     take;
    logic     mul_load;
    logic     div_start;
    div_sel_e div_sel;
    logic     bnd_store;
    bnd_e     bnd_idx;
    logic     roi_avg_store;
    logic     frm_avg_store;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cfg_wr;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/thermal_roi_min_max_mean.sv
// Top level of the thermal ROI min/max/mean statistics block.
// Depends on trmm_pkg, trmm_ctrl, trmm_dp (which holds trmm_div).
//
//   channel  handshake                    payload
//   sample   sample_valid / sample_stall  sample (temp_sample, frame_last)
//   result   result_valid / result_stall  result (ROI and frame statistics)
//   cfg      cfg_valid / cfg_ready        cfg_index, cfg_data
//
// Inside a frame one sample transfers per cycle. Before a frame's first
// sample the four ROI bounds are scaled by the 37-step shared divider;
// after frame_last two averages are computed on the same divider, then the
// result is registered. A result waiting on result_stall does not block
// the next frame until its averages are done. Reset is synchronous; cfg
// is always ready, and a write during frame setup restarts it.
module thermal_roi_min_max_mean (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  trmm_pkg::sample_t                  sample,
  output logic                               result_valid,
  input  logic                               result_stall,
  output trmm_pkg::result_t                  result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [trmm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [trmm_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  trmm_pkg::ctrl_cmd_t  cmd;
  trmm_pkg::dp_status_t status;
  logic                 cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  trmm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .frame_last   (sample.frame_last),
    .status       (status),
    .sample_stall (sample_stall),
    .cmd          (cmd)
  );

  trmm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_wr       (cfg_wr),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample       (sample),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

  a_empty_roi: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.roi_valid |-> result.roi_count == '0)
    else $error("empty rectangle reported samples");

  a_roi_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.roi_count == '0 |->
      result.roi_min == '0 && result.roi_max == '0 && result.roi_avg == '0)
    else $error("ROI fields not zero with no samples");

  a_frame_order: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      result.frame_min <= result.frame_avg && result.frame_avg <= result.frame_max)
    else $error("frame average outside min/max");

  a_roi_order: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.roi_count != '0 |->
      result.roi_min <= result.roi_avg && result.roi_avg <= result.roi_max)
    else $error("ROI average outside min/max");

endmodule

FILE: rtl/trmm_div.sv
// Shared restoring divider, one quotient bit per cycle (unsigned).
// Depends on trmm_pkg for operand widths.
module trmm_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [trmm_pkg::SUM_BITS-1:0] dividend,
  input  logic [trmm_pkg::CNT_BITS-1:0] divisor,
  output logic                          done,
  output logic [trmm_pkg::SUM_BITS-1:0] quotient
);

  localparam int CW = $clog2(trmm_pkg::SUM_BITS + 1);

  logic                          busy;
  logic [CW-1:0]                 cnt;
  logic [trmm_pkg::SUM_BITS-1:0] quo;
  logic [trmm_pkg::CNT_BITS-1:0] rem;
  logic [trmm_pkg::CNT_BITS-1:0] dvs;
  logic [trmm_pkg::CNT_BITS:0]   rem_sh;
  logic [trmm_pkg::CNT_BITS:0]   diff;
  logic                          ge;

  assign rem_sh   = {rem, quo[trmm_pkg::SUM_BITS-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign diff     = rem_sh - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(trmm_pkg::SUM_BITS);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[trmm_pkg::SUM_BITS-2:0], ge};
      rem <= ge ? diff[trmm_pkg::CNT_BITS-1:0] : rem_sh[trmm_pkg::CNT_BITS-1:0];
    end
  end

endmodule

FILE: rtl/trmm_dp.sv
// Datapath: configuration registers, ROI bound scaling, running statistics,
// averaging through the shared divider, and the result register.
// Depends on trmm_pkg and trmm_div.
module trmm_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  trmm_pkg::ctrl_cmd_t                cmd,
  output trmm_pkg::dp_status_t               status,
  input  logic                               cfg_wr,
  input  logic [trmm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [trmm_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  trmm_pkg::sample_t                  sample,
  input  logic                               result_stall,
  output logic                               result_valid,
  output trmm_pkg::result_t                  result
);

  localparam int IB = trmm_pkg::IMG_BITS;
  localparam int MB = trmm_pkg::MDIM_BITS;
  localparam int DB = trmm_pkg::DIM_BITS;
  localparam int CB = trmm_pkg::COORD_BITS;
  localparam int SB = trmm_pkg::SUM_BITS;
  localparam int NB = trmm_pkg::CNT_BITS;
  localparam int TB = trmm_pkg::TEMP_BITS;

  function automatic logic [IB-1:0] clamp_coord(input logic signed [CB-1:0] v,
                                                input logic [IB-1:0] lim);
    logic signed [CB:0] v_ext;
    logic signed [CB:0] lim_ext;
    v_ext   = (CB+1)'(v);
    lim_ext = $signed((CB+1)'(lim));
    if (v_ext < 0) return '0;
    else if (v_ext > lim_ext) return lim;
    else return v_ext[IB-1:0];
  endfunction

  // configuration
  logic [IB-1:0]        img_w, img_h;
  logic [MB-1:0]        mat_w, mat_h;
  logic signed [CB-1:0] roi_l, roi_t, roi_r, roi_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_w <= trmm_pkg::IMG_W_RST;
      img_h <= trmm_pkg::IMG_H_RST;
      mat_w <= trmm_pkg::MAT_W_RST;
      mat_h <= trmm_pkg::MAT_H_RST;
      roi_l <= '0;
      roi_t <= '0;
      roi_r <= '0;
      roi_b <= '0;
    end else if (cfg_wr) begin
      case (trmm_pkg::cfg_reg_e'(cfg_index))
        trmm_pkg::REG_IMAGE_WIDTH:   img_w <= cfg_data[IB-1:0];
        trmm_pkg::REG_IMAGE_HEIGHT:  img_h <= cfg_data[IB-1:0];
        trmm_pkg::REG_MATRIX_WIDTH:  mat_w <= cfg_data[MB-1:0];
        trmm_pkg::REG_MATRIX_HEIGHT: mat_h <= cfg_data[MB-1:0];
        trmm_pkg::REG_ROI_LEFT:      roi_l <= $signed(cfg_data[CB-1:0]);
        trmm_pkg::REG_ROI_TOP:       roi_t <= $signed(cfg_data[CB-1:0]);
        trmm_pkg::REG_ROI_RIGHT:     roi_r <= $signed(cfg_data[CB-1:0]);
        trmm_pkg::REG_ROI_BOTTOM:    roi_b <= $signed(cfg_data[CB-1:0]);
        default: ;
      endcase
    end
  end

  // effective dimensions
  logic [IB-1:0] iw, ih;
  logic [MB-1:0] mw, mh;

  assign iw = (img_w == '0) ? IB'(1) : img_w;
  assign ih = (img_h == '0) ? IB'(1) : img_h;
  assign mw = (mat_w == '0) ? MB'(1) :
              (mat_w > MB'(trmm_pkg::MAX_DIM)) ? MB'(trmm_pkg::MAX_DIM) : mat_w;
  assign mh = (mat_h == '0) ? MB'(1) :
              (mat_h > MB'(trmm_pkg::MAX_DIM)) ? MB'(trmm_pkg::MAX_DIM) : mat_h;

  // normalized, clamped rectangle
  logic [IB-1:0] x_lo, x_hi, y_lo, y_hi;

  assign x_lo = clamp_coord((roi_l < roi_r) ? roi_l : roi_r, iw);
  assign x_hi = clamp_coord((roi_l < roi_r) ? roi_r : roi_l, iw);
  assign y_lo = clamp_coord((roi_t < roi_b) ? roi_t : roi_b, ih);
  assign y_hi = clamp_coord((roi_t < roi_b) ? roi_b : roi_t, ih);

  // bound scaling: product, then divide by image dimension
  logic [IB-1:0]                  mul_coord;
  logic [MB-1:0]                  mul_dim;
  logic [trmm_pkg::PROD_BITS-1:0] prod;
  logic                           roi_ok;
  logic [DB-1:0]                  bnd [4];

  always_comb begin
    case (cmd.bnd_idx)
      trmm_pkg::BND_X_LO: mul_coord = x_lo;
      trmm_pkg::BND_Y_LO: mul_coord = y_lo;
      trmm_pkg::BND_X_HI: mul_coord = x_hi;
      trmm_pkg::BND_Y_HI: mul_coord = y_hi;
      default:            mul_coord = x_lo;
    endcase
    mul_dim = cmd.bnd_idx[0] ? mh : mw;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      prod <= trmm_pkg::PROD_BITS'(mul_coord) * trmm_pkg::PROD_BITS'(mul_dim);
      if (cmd.bnd_idx == trmm_pkg::BND_X_LO) begin
        roi_ok <= (x_hi > x_lo) && (y_hi > y_lo);
      end
    end
  end

  // statistics
  trmm_pkg::temp_t      roi_min_acc, roi_max_acc, frame_min_acc, frame_max_acc;
  logic signed [SB-1:0] roi_sum_acc, frame_sum_acc;
  logic [NB-1:0]        roi_count_acc, frame_count;
  logic [DB-1:0]        col_counter, row_counter;
  logic                 full;
  logic [DB:0]          col_inc, row_inc;
  logic                 col_wrap, row_wrap;
  logic                 in_roi;
  logic                 upd;
  trmm_pkg::temp_t      t;

  assign t        = sample.temp_sample;
  assign upd      = cmd.take && !full;
  assign col_inc  = {1'b0, col_counter} + (DB+1)'(1);
  assign row_inc  = {1'b0, row_counter} + (DB+1)'(1);
  assign col_wrap = col_inc >= (DB+1)'(mw);
  assign row_wrap = row_inc >= (DB+1)'(mh);
  assign in_roi   = roi_ok &&
                    col_counter >= bnd[trmm_pkg::BND_X_LO] &&
                    col_counter <= bnd[trmm_pkg::BND_X_HI] &&
                    row_counter >= bnd[trmm_pkg::BND_Y_LO] &&
                    row_counter <= bnd[trmm_pkg::BND_Y_HI];

  always_ff @(posedge clk) begin
    if (rst || cmd.out_load) begin
      roi_min_acc   <= trmm_pkg::TEMP_MAX;
      roi_max_acc   <= trmm_pkg::TEMP_MIN;
      roi_sum_acc   <= '0;
      roi_count_acc <= '0;
      frame_min_acc <= trmm_pkg::TEMP_MAX;
      frame_max_acc <= trmm_pkg::TEMP_MIN;
      frame_sum_acc <= '0;
      frame_count   <= '0;
      col_counter   <= '0;
      row_counter   <= '0;
      full          <= 1'b0;
    end else if (upd) begin
      if (t < frame_min_acc) frame_min_acc <= t;
      if (t > frame_max_acc) frame_max_acc <= t;
      frame_sum_acc <= frame_sum_acc + SB'(t);
      frame_count   <= frame_count + NB'(1);
      if (in_roi) begin
        if (t < roi_min_acc) roi_min_acc <= t;
        if (t > roi_max_acc) roi_max_acc <= t;
        roi_sum_acc   <= roi_sum_acc + SB'(t);
        roi_count_acc <= roi_count_acc + NB'(1);
      end
      if (col_wrap) begin
        col_counter <= '0;
        if (row_wrap) begin
          row_counter <= '0;
          full        <= 1'b1;
        end else begin
          row_counter <= row_inc[DB-1:0];
        end
      end else begin
        col_counter <= col_inc[DB-1:0];
      end
    end
  end

  // divider operands
  logic [SB-1:0] div_dividend;
  logic [NB-1:0] div_divisor;
  logic [SB-1:0] div_q;
  logic          div_done;

  always_comb begin
    case (cmd.div_sel)
      trmm_pkg::DIV_ROI: begin
        div_dividend = roi_sum_acc[SB-1] ? SB'(-roi_sum_acc) : SB'(roi_sum_acc);
        div_divisor  = roi_count_acc;
      end
      trmm_pkg::DIV_FRAME: begin
        div_dividend = frame_sum_acc[SB-1] ? SB'(-frame_sum_acc) : SB'(frame_sum_acc);
        div_divisor  = frame_count;
      end
      default: begin
        div_dividend = SB'(prod);
        div_divisor  = cmd.bnd_idx[0] ? NB'(ih) : NB'(iw);
      end
    endcase
  end

  trmm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // bound store with clamp to last index; averages with sign restored
  logic [MB-1:0]   st_dim;
  logic [TB-1:0]   q_lo;
  trmm_pkg::temp_t roi_avg, frame_avg;

  assign st_dim = cmd.bnd_idx[0] ? mh : mw;
  assign q_lo   = div_q[TB-1:0];

  always_ff @(posedge clk) begin
    if (cmd.bnd_store) begin
      bnd[cmd.bnd_idx] <= (div_q >= SB'(st_dim)) ? DB'(st_dim - MB'(1)) : div_q[DB-1:0];
    end
    if (cmd.roi_avg_store) begin
      roi_avg <= roi_sum_acc[SB-1] ? $signed(-q_lo) : $signed(q_lo);
    end
    if (cmd.frm_avg_store) begin
      frame_avg <= frame_sum_acc[SB-1] ? $signed(-q_lo) : $signed(q_lo);
    end
  end

  // result register
  logic roi_any;

  assign roi_any = roi_count_acc != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.roi_valid <= roi_ok;
      result.roi_min   <= roi_any ? roi_min_acc : '0;
      result.roi_max   <= roi_any ? roi_max_acc : '0;
      result.roi_avg   <= roi_any ? roi_avg : '0;
      result.roi_count <= roi_count_acc;
      result.frame_min <= frame_min_acc;
      result.frame_max <= frame_max_acc;
      result.frame_avg <= frame_avg;
    end
  end

  assign status.cfg_wr   = cfg_wr;
  assign status.div_done = div_done;
  assign status.out_free = !result_valid || !result_stall;

endmodule

FILE: rtl/trmm_ctrl.sv
// Controller: frame setup (bound scaling), sample streaming, end-of-frame
// averaging and result hand-off. Depends on trmm_pkg.
module trmm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  input  logic                 frame_last,
  input  trmm_pkg::dp_status_t status,
  output logic                 sample_stall,
  output trmm_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_WAIT,
    S_RUN,
    S_ROI_DIV,
    S_ROI_WAIT,
    S_FRM_DIV,
    S_FRM_WAIT,
    S_OUT
  } state_t;

  state_t         state;
  trmm_pkg::bnd_e idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= trmm_pkg::BND_X_LO;
    end else if (status.cfg_wr && (state inside {S_MUL, S_DIV, S_WAIT})) begin
      // register changed during setup: start over
      state <= S_MUL;
      idx   <= trmm_pkg::BND_X_LO;
    end else begin
      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            state <= S_MUL;
            idx   <= trmm_pkg::BND_X_LO;
          end
        end
        S_MUL: state <= S_DIV;
        S_DIV: state <= S_WAIT;
        S_WAIT: begin
          if (status.div_done) begin
            if (idx == trmm_pkg::BND_Y_HI) begin
              state <= S_RUN;
            end else begin
              idx   <= trmm_pkg::bnd_e'(idx + 2'd1);
              state <= S_MUL;
            end
          end
        end
        S_RUN: begin
          if (sample_valid && frame_last) state <= S_ROI_DIV;
        end
        S_ROI_DIV: state <= S_ROI_WAIT;
        S_ROI_WAIT: begin
          if (status.div_done) state <= S_FRM_DIV;
        end
        S_FRM_DIV: state <= S_FRM_WAIT;
        S_FRM_WAIT: begin
          if (status.div_done) state <= S_OUT;
        end
        S_OUT: begin
          if (status.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign sample_stall = (state != S_RUN);

  always_comb begin
    cmd         = '0;
    cmd.bnd_idx = idx;
    cmd.div_sel = trmm_pkg::DIV_BOUND;
    case (state)
      S_MUL: cmd.mul_load = 1'b1;
      S_DIV: cmd.div_start = 1'b1;
      S_WAIT: cmd.bnd_store = status.div_done;
      S_RUN: cmd.take = sample_valid;
      S_ROI_DIV: begin
        cmd.div_sel   = trmm_pkg::DIV_ROI;
        cmd.div_start = 1'b1;
      end
      S_ROI_WAIT: begin
        cmd.div_sel       = trmm_pkg::DIV_ROI;
        cmd.roi_avg_store = status.div_done;
      end
      S_FRM_DIV: begin
        cmd.div_sel   = trmm_pkg::DIV_FRAME;
        cmd.div_start = 1'b1;
      end
      S_FRM_WAIT: begin
        cmd.div_sel       = trmm_pkg::DIV_FRAME;
        cmd.frm_avg_store = status.div_done;
      end
      S_OUT: cmd.out_load = status.out_free;
      default: ;
    endcase
  end

endmodule

FILE: bench/tb_top.sv
// Testbench for the thermal ROI min/max/mean statistics block (thermal_roi_min_max_mean).
// Uses trmm_pkg and the RTL only. A built-in frame statistics predictor checks every result.
// Directed corner frames come first, then random windows and frames, with or without stalls.
module tb_top;
  import trmm_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES   = 900;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  sample_t sample = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  thermal_roi_min_max_mean dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register shadow and frame statistics predictor state
  logic [CFG_DATA_BITS-1:0] cfg_shadow [8];
  bit     in_frame;
  bit     roi_ok;
  int     col, row;
  int     bx_lo, by_lo, bx_hi, by_hi;
  int     roi_min, roi_max, roi_cnt;
  longint roi_sum;
  int     frm_min, frm_max, frm_cnt;
  longint frm_sum;
  result_t stats_due [$];

  int  errors;
  int  samples_sent;
  int  frames_checked;
  int  setups_written;
  int  cycles;
  bit  gaps_on = 1'b1;
  int  hold_requests;
  int  hold_served;
  int  hold_left;

  function automatic int clip(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int img_eff(cfg_reg_e r);
    int v;
    v = cfg_shadow[r][IMG_BITS-1:0];
    return v == 0 ? 1 : v;
  endfunction

  function automatic int mat_eff(cfg_reg_e r);
    int v;
    v = cfg_shadow[r][MDIM_BITS-1:0];
    return clip(v, 1, MAX_DIM);
  endfunction

  function automatic int coord(cfg_reg_e r);
    return int'($signed(cfg_shadow[r]));
  endfunction

  function automatic void clear_frame();
    in_frame = 1'b0;
    col = 0;
    row = 0;
    roi_min = int'(TEMP_MAX);
    roi_max = int'(TEMP_MIN);
    roi_sum = 0;
    roi_cnt = 0;
    frm_min = int'(TEMP_MAX);
    frm_max = int'(TEMP_MIN);
    frm_sum = 0;
    frm_cnt = 0;
  endfunction

  function automatic void latch_window();
    int iw, ih, mw, mh, a, b, c, d, xl, xh, yl, yh;
    iw = img_eff(REG_IMAGE_WIDTH);
    ih = img_eff(REG_IMAGE_HEIGHT);
    mw = mat_eff(REG_MATRIX_WIDTH);
    mh = mat_eff(REG_MATRIX_HEIGHT);
    a = coord(REG_ROI_LEFT);
    b = coord(REG_ROI_TOP);
    c = coord(REG_ROI_RIGHT);
    d = coord(REG_ROI_BOTTOM);
    xl = clip(a < c ? a : c, 0, iw);
    xh = clip(a < c ? c : a, 0, iw);
    yl = clip(b < d ? b : d, 0, ih);
    yh = clip(b < d ? d : b, 0, ih);
    roi_ok = (xh > xl) && (yh > yl);
    bx_lo = clip(xl * mw / iw, 0, mw - 1);
    by_lo = clip(yl * mh / ih, 0, mh - 1);
    bx_hi = clip(xh * mw / iw, 0, mw - 1);
    by_hi = clip(yh * mh / ih, 0, mh - 1);
  endfunction

  function automatic void account_sample(temp_t t, logic last);
    int v, mw, mh;
    result_t r;
    v = t;
    mw = mat_eff(REG_MATRIX_WIDTH);
    mh = mat_eff(REG_MATRIX_HEIGHT);
    if (!in_frame) begin
      latch_window();
      in_frame = 1'b1;
    end
    if (frm_cnt < mw * mh) begin
      if (v < frm_min) frm_min = v;
      if (v > frm_max) frm_max = v;
      frm_sum += v;
      frm_cnt++;
      if (roi_ok && col >= bx_lo && col <= bx_hi && row >= by_lo && row <= by_hi) begin
        if (v < roi_min) roi_min = v;
        if (v > roi_max) roi_max = v;
        roi_sum += v;
        roi_cnt++;
      end
      col++;
      if (col >= mw) begin
        col = 0;
        row++;
        if (row >= mh) row = 0;
      end
    end
    if (last) begin
      r = '0;
      r.roi_valid = roi_ok;
      if (roi_cnt > 0) begin
        r.roi_min = temp_t'(roi_min);
        r.roi_max = temp_t'(roi_max);
        r.roi_avg = temp_t'(roi_sum / roi_cnt);
      end
      r.roi_count = CNT_BITS'(roi_cnt);
      r.frame_min = temp_t'(frm_min);
      r.frame_max = temp_t'(frm_max);
      r.frame_avg = temp_t'(frm_sum / frm_cnt);
      stats_due = {stats_due, r};
      clear_frame();
    end
  endfunction

  // result side: random stalls plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= gaps_on && ($urandom_range(99) < 22);
    end
  end

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (stats_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer, actual %p", $time, result);
      end else begin
        want = stats_due.pop_front();
        frames_checked++;
        check_field("roi_valid", want.roi_valid, result.roi_valid);
        check_field("roi_min", want.roi_min, result.roi_min);
        check_field("roi_max", want.roi_max, result.roi_max);
        check_field("roi_avg", want.roi_avg, result.roi_avg);
        check_field("roi_count", want.roi_count, result.roi_count);
        check_field("frame_min", want.frame_min, result.frame_min);
        check_field("frame_max", want.frame_max, result.frame_max);
        check_field("frame_avg", want.frame_avg, result.frame_avg);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, stats_due.size());
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_sample(input temp_t t, input logic last);
    while (gaps_on && $urandom_range(99) < 22) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= '{temp_sample: t, frame_last: last};
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    samples_sent++;
    account_sample(t, last);
  endtask

  task automatic wait_idle();
    sample_valid <= 1'b0;
    while (stats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_setup(input int iw, input int ih, input int mw, input int mh,
                             input int x0, input int y0, input int x1, input int y1);
    logic [CFG_DATA_BITS-1:0] vals [8];
    cfg_reg_e idx;
    vals[REG_IMAGE_WIDTH]   = CFG_DATA_BITS'(iw);
    vals[REG_IMAGE_HEIGHT]  = CFG_DATA_BITS'(ih);
    vals[REG_MATRIX_WIDTH]  = CFG_DATA_BITS'(mw);
    vals[REG_MATRIX_HEIGHT] = CFG_DATA_BITS'(mh);
    vals[REG_ROI_LEFT]      = CFG_DATA_BITS'(x0);
    vals[REG_ROI_TOP]       = CFG_DATA_BITS'(y0);
    vals[REG_ROI_RIGHT]     = CFG_DATA_BITS'(x1);
    vals[REG_ROI_BOTTOM]    = CFG_DATA_BITS'(y1);
    idx = idx.first();
    repeat (idx.num()) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= vals[idx];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      cfg_shadow[idx] = vals[idx];
      idx = idx.next();
    end
    cfg_valid <= 1'b0;
    setups_written++;
  endtask

  function automatic temp_t rand_temp();
    case ($urandom_range(9))
      0: return TEMP_MAX;
      1: return TEMP_MIN;
      2: return temp_t'(int'($urandom_range(0, 10)) - 5);
      default: return temp_t'($urandom);
    endcase
  endfunction

  function automatic int pick_matrix_dim();
    return ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(0, 2047);
  endfunction

  function automatic int pick_image_dim(int m);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return (m >= 1 && m <= MAX_DIM) ? m * $urandom_range(1, 4)
                                                     : $urandom_range(1, 64);
      5, 6, 7: return $urandom_range(1, 64);
      default: return $urandom_range(0, 8191);
    endcase
  endfunction

  function automatic int pick_coord(int d);
    if ($urandom_range(99) < 70) return int'($urandom_range(0, d + 4)) - 2;
    return int'($urandom_range(0, 16383)) - 8192;
  endfunction

  // big matrices only get short frames; small ones are mostly exact, some short or long
  function automatic int pick_frame_len();
    int n;
    n = mat_eff(REG_MATRIX_WIDTH) * mat_eff(REG_MATRIX_HEIGHT);
    if (n > 48) return $urandom_range(1, 20);
    case ($urandom_range(9))
      0: return (n > 1) ? $urandom_range(1, n - 1) : 1;
      1: return n + $urandom_range(1, 4);
      default: return n;
    endcase
  endfunction

  task automatic send_frame(input int len);
    for (int k = 0; k < len; k++) send_sample(rand_temp(), k == len - 1);
  endtask

  task automatic random_setup();
    int mw, mh, iw, ih;
    mw = pick_matrix_dim();
    mh = pick_matrix_dim();
    iw = pick_image_dim(mw);
    ih = pick_image_dim(mh);
    wait_idle();
    write_setup(iw, ih, mw, mh, pick_coord(iw), pick_coord(ih), pick_coord(iw), pick_coord(ih));
  endtask

  task automatic test_reset_defaults();
    send_sample(TEMP_MAX, 1'b0);
    send_sample(TEMP_MIN, 1'b0);
    send_sample(temp_t'(0), 1'b1);
  endtask

  task automatic test_full_window();
    wait_idle();
    write_setup(2, 2, 2, 2, 2, 2, 0, 0);
    send_sample(TEMP_MIN, 1'b0);
    send_sample(TEMP_MAX, 1'b0);
    send_sample(temp_t'(1), 1'b0);
    send_sample(temp_t'(-1), 1'b1);
  endtask

  task automatic test_overlong_frame();
    send_sample(temp_t'(100), 1'b0);
    send_sample(temp_t'(200), 1'b0);
    send_sample(temp_t'(300), 1'b0);
    send_sample(temp_t'(400), 1'b0);
    send_sample(TEMP_MIN, 1'b0);
    send_sample(TEMP_MAX, 1'b1);
  endtask

  task automatic test_dimension_clamp();
    wait_idle();
    write_setup(0, 8191, 2047, 0, -8192, -8192, 8191, 8191);
    send_sample(temp_t'(-7), 1'b0);
    send_sample(temp_t'(12), 1'b0);
    send_sample(temp_t'(30000), 1'b1);
  endtask

  task automatic test_window_not_reached();
    wait_idle();
    write_setup(8191, 8191, 4, 4, 8191, 8191, 8000, 8000);
    send_sample(temp_t'(5), 1'b0);
    send_sample(temp_t'(-5), 1'b1);
  endtask

  task automatic test_random_frames(input int quota);
    int sent, len;
    sent = 0;
    while (sent < quota) begin
      random_setup();
      repeat ($urandom_range(1, 4)) begin
        len = pick_frame_len();
        send_frame(len);
        sent += len;
      end
    end
  endtask

  task automatic test_back_to_back(input int quota);
    gaps_on = 1'b0;
    test_random_frames(quota);
    gaps_on = 1'b1;
  endtask

  task automatic test_result_hold();
    wait_idle();
    write_setup(2, 2, 2, 2, 0, 0, 1, 1);
    hold_requests++;
    repeat (8) send_frame(4);
  endtask

  initial begin
    cfg_shadow[REG_IMAGE_WIDTH]   = CFG_DATA_BITS'(IMG_W_RST);
    cfg_shadow[REG_IMAGE_HEIGHT]  = CFG_DATA_BITS'(IMG_H_RST);
    cfg_shadow[REG_MATRIX_WIDTH]  = CFG_DATA_BITS'(MAT_W_RST);
    cfg_shadow[REG_MATRIX_HEIGHT] = CFG_DATA_BITS'(MAT_H_RST);
    cfg_shadow[REG_ROI_LEFT]      = '0;
    cfg_shadow[REG_ROI_TOP]       = '0;
    cfg_shadow[REG_ROI_RIGHT]     = '0;
    cfg_shadow[REG_ROI_BOTTOM]    = '0;
    clear_frame();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_full_window();
    test_overlong_frame();
    test_dimension_clamp();
    test_window_not_reached();
    test_random_frames(650);
    test_back_to_back(200);
    test_result_hold();
    test_random_frames(150);
    wait_idle();

    $display("summary: %0d samples, %0d frame results checked, %0d register setups",
             samples_sent, frames_checked, setups_written);
    $display("summary: empty, clamped and unreached windows, short and overlong frames, holds");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/trmm_pkg.sv
rtl/trmm_div.sv
rtl/trmm_dp.sv
rtl/trmm_ctrl.sv
rtl/thermal_roi_min_max_mean.sv
bench/tb_top.sv
